FILE: src/ipmbb_pkg.sv
// Shared constants and types for the image pair meet bounding box block.
package ipmbb_pkg;

    // Store geometry and pixel size
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int PIXEL_BITS = 8;

    localparam int ROW_W   = 6;   // row field width
    localparam int COL_W   = 6;   // column field width
    localparam int DIM_W   = 7;   // dimension field width
    localparam int PIX_W   = 8;   // pixel field width
    localparam int CELL_W  = 9;   // signed consensus cell width
    localparam int ADDR_W  = $clog2(MAX_HEIGHT * MAX_WIDTH);
    localparam int DEPTH   = MAX_HEIGHT * MAX_WIDTH;
    localparam int SROW_W  = $clog2(MAX_HEIGHT);
    localparam int SCOL_W  = $clog2(MAX_WIDTH);

    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    localparam logic [CELL_W-1:0] WILDCARD = {CELL_W{1'b1}};

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_UNUSED_2     = 2'd2,
        REG_UNUSED_3     = 2'd3
    } cfg_index_t;

    // Bounding box as shown in a result beat
    typedef struct packed {
        logic [ROW_W-1:0] top;
        logic [COL_W-1:0] left;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] width;
    } box_view_t;

    // Clamp a configured dimension to 1..max
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: src/image_pair_meet_bounding_box.sv
// Image pair meet: consensus store in a synchronous RAM with bounding box tracking.
// A beat accepted on s_ is registered in the stage register, together with any RAM read
// data, and moves on into the output register, which offers it on m_, once that is free.
// Throughput: one beat per cycle while m_tready is high; set by the single RAM port,
// which writes or reads once at the accepting edge and registers the read data.
// One beat is taken while an earlier result waits on the output register.
// Reset (aresetn low, synchronous): box and valid flags clear, dimensions return to 64;
// the consensus RAM is not cleared and reads of never-written cells are undefined.
module image_pair_meet_bounding_box
    import ipmbb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // row[5:0], col[11:6], pixel_a[19:12], pixel_b[27:20]
    input  logic [1:0]             s_tuser,   // opcode[1:0]
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // cell_value[8:0], meet_top[14:9], meet_left[20:15],
                                              // meet_height[27:21], meet_width[34:28]
    output logic                   m_tuser    // status[0]
);

    // Configuration registers
    logic [DIM_W-1:0] image_width_reg, image_height_reg;

    // Box state
    logic             seen_solid_reg, seen_solid_next;
    logic [ROW_W-1:0] box_top_reg, box_top_next, box_bottom_reg, box_bottom_next;
    logic [COL_W-1:0] box_left_reg, box_left_next, box_right_reg, box_right_next;

    // Stage between RAM access and output register
    logic              s1_valid_reg;
    logic              s1_from_mem_reg;
    logic [CELL_W-1:0] s1_cell_reg;
    logic              s1_status_reg;
    box_view_t         s1_box_reg;

    // Output register
    logic              m_valid_reg;
    logic [CELL_W-1:0] m_cell_reg;
    logic              m_status_reg;
    box_view_t         m_box_reg;

    // RAM
    logic [CELL_W-1:0] mem [0:DEPTH-1];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [CELL_W-1:0] mem_wdata;

    // Decoded input beat
    opcode_t          op;
    logic [ROW_W-1:0] in_row;
    logic [COL_W-1:0] in_col;
    logic [PIX_W-1:0] in_pa, in_pb;
    logic             s_accept, out_free, s1_move;
    logic [DIM_W-1:0] use_w, use_h;
    logic             load_outside, read_outside;
    logic [ROW_W-1:0] box_h_span, rd_row;
    logic [COL_W-1:0] box_w_span, rd_col;
    logic [CELL_W-1:0] load_value, cell_now;
    logic             status_now, solid_load;
    box_view_t        view_next;

    assign op     = opcode_t'(s_tuser);
    assign in_row = s_tdata[5:0];
    assign in_col = s_tdata[11:6];
    assign in_pa  = s_tdata[19:12];
    assign in_pb  = s_tdata[27:20];

    // Handshake: the stage drains into the output register when it is free
    assign out_free = !m_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Range checks
    assign use_w        = clamp_dim(image_width_reg, MAX_W_DIM);
    assign use_h        = clamp_dim(image_height_reg, MAX_H_DIM);
    assign load_outside = ({1'b0, in_row} >= use_h) || ({1'b0, in_col} >= use_w);
    assign box_h_span   = box_bottom_reg - box_top_reg;
    assign box_w_span   = box_right_reg - box_left_reg;
    assign read_outside = !seen_solid_reg || (in_row > box_h_span) || (in_col > box_w_span);
    assign rd_row       = box_top_reg + in_row;
    assign rd_col       = box_left_reg + in_col;

    assign load_value = (in_pa[PIXEL_BITS-1:0] == in_pb[PIXEL_BITS-1:0])
                        ? {{(CELL_W-PIXEL_BITS){1'b0}}, in_pa[PIXEL_BITS-1:0]} : WILDCARD;
    assign solid_load = (op == OP_LOAD) && !load_outside && (load_value != WILDCARD);

    // Box update and result fields for the beat at the input
    always_comb begin
        seen_solid_next = seen_solid_reg;
        box_top_next    = box_top_reg;
        box_bottom_next = box_bottom_reg;
        box_left_next   = box_left_reg;
        box_right_next  = box_right_reg;
        cell_now        = '0;
        status_now      = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = {in_row[SROW_W-1:0], in_col[SCOL_W-1:0]};
        mem_wdata       = load_value;
        case (op)
            OP_CLEAR: begin
                seen_solid_next = 1'b0;
                box_top_next    = '0;
                box_bottom_next = '0;
                box_left_next   = '0;
                box_right_next  = '0;
            end
            OP_LOAD: begin
                if (load_outside) begin
                    status_now = 1'b1;
                end else begin
                    cell_now = load_value;
                    mem_we   = s_accept;
                    if (solid_load) begin
                        seen_solid_next = 1'b1;
                        if (!seen_solid_reg) begin
                            box_top_next    = in_row;
                            box_bottom_next = in_row;
                            box_left_next   = in_col;
                            box_right_next  = in_col;
                        end else begin
                            if (in_row < box_top_reg)    box_top_next    = in_row;
                            if (in_row > box_bottom_reg) box_bottom_next = in_row;
                            if (in_col < box_left_reg)   box_left_next   = in_col;
                            if (in_col > box_right_reg)  box_right_next  = in_col;
                        end
                    end
                end
            end
            OP_READ: begin
                mem_addr = {rd_row[SROW_W-1:0], rd_col[SCOL_W-1:0]};
                if (read_outside) begin
                    status_now = 1'b1;
                end else begin
                    mem_re = s_accept;
                end
            end
            default: begin
            end
        endcase
    end

    // Box as it stands after the step
    always_comb begin
        view_next = '0;
        if (seen_solid_next) begin
            view_next.top    = box_top_next;
            view_next.left   = box_left_next;
            view_next.height = DIM_W'(box_bottom_next - box_top_next) + DIM_W'(1);
            view_next.width  = DIM_W'(box_right_next - box_left_next) + DIM_W'(1);
        end
    end

    // Consensus RAM: at most one access per accepted beat, read data registered
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= DIM_RESET;
            image_height_reg <= DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Box state advances at each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_solid_reg <= 1'b0;
            box_top_reg    <= '0;
            box_bottom_reg <= '0;
            box_left_reg   <= '0;
            box_right_reg  <= '0;
        end else if (s_accept) begin
            seen_solid_reg <= seen_solid_next;
            box_top_reg    <= box_top_next;
            box_bottom_reg <= box_bottom_next;
            box_left_reg   <= box_left_next;
            box_right_reg  <= box_right_next;
        end
    end

    // Hold the beat's result while the RAM read completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_from_mem_reg <= mem_re;
            s1_cell_reg     <= cell_now;
            s1_status_reg   <= status_now;
            s1_box_reg      <= view_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_cell_reg   <= s1_from_mem_reg ? rd_data_reg : s1_cell_reg;
            m_status_reg <= s1_status_reg;
            m_box_reg    <= s1_box_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {5'd0, m_box_reg.width, m_box_reg.height, m_box_reg.left,
                       m_box_reg.top, m_cell_reg};

    // Box corners stay ordered once a solid cell has been seen
    a_box_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_solid_reg |-> (box_top_reg <= box_bottom_reg) && (box_left_reg <= box_right_reg))
        else $error("bounding box corners out of order");

    // An empty meet keeps the box at zero
    a_empty_box_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_solid_reg |-> (box_top_reg == '0) && (box_bottom_reg == '0)
                            && (box_left_reg == '0) && (box_right_reg == '0))
        else $error("empty meet with nonzero box");

    // A waiting stage blocks new beats while the output register is full
    a_stage_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while stage is blocked");

    // A stage held by a stall keeps its read data
    a_rd_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_move) |=> $stable(rd_data_reg))
        else $error("read data changed under a stalled stage");

    // Each accepted beat is followed by a valid stage
    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> s1_valid_reg)
        else $error("accepted beat lost before output");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Testbench for image_pair_meet_bounding_box: directed and random beats checked against a predictor.
module tb;
    import ipmbb_pkg::*;

    // One expected result beat, split into its fields
    typedef struct {
        logic signed [CELL_W-1:0] value;
        logic [ROW_W-1:0]         top;
        logic [COL_W-1:0]         left;
        logic [DIM_W-1:0]         height;
        logic [DIM_W-1:0]         width;
        logic                     status;
    } meet_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b1;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // Predictor state: consensus store, written map, pair tag per cell, box and dimensions
    logic signed [CELL_W-1:0] meet_store [DEPTH];
    bit                       cell_written [DEPTH];
    int                       cell_pair [DEPTH];
    int                       pair_id = 0;
    bit                       box_valid = 1'b0;
    logic [ROW_W-1:0]         box_top = '0, box_bottom = '0;
    logic [COL_W-1:0]         box_left = '0, box_right = '0;
    logic [ROW_W-1:0]         last_solid_row = '0;
    logic [COL_W-1:0]         last_solid_col = '0;
    logic [DIM_W-1:0]         reg_width = DIM_RESET, reg_height = DIM_RESET;

    meet_result_t pending_results [$];

    int err_count = 0;
    int n_items = 0, n_loads = 0, n_reads = 0, n_stale = 0, n_clears = 0, n_checked = 0;
    int n_settings = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    image_pair_meet_bounding_box dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 aclk = ~aclk;

    // Random backpressure on the result stream
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Dimension actually in use: zero counts as one, oversize clips to the maximum
    function automatic logic [DIM_W-1:0] dim_in_use(logic [DIM_W-1:0] v,
                                                    logic [DIM_W-1:0] maxv);
        if (v == '0) begin
            return DIM_W'(1);
        end
        return (v > maxv) ? maxv : v;
    endfunction

    // Advance the predicted state by one beat and return the result it should produce
    function automatic meet_result_t predict_meet(opcode_t op, logic [ROW_W-1:0] r,
                                                  logic [COL_W-1:0] c,
                                                  logic [PIX_W-1:0] pa, logic [PIX_W-1:0] pb);
        meet_result_t res;
        logic [CELL_W-1:0] v;
        int idx;
        res.value  = '0;
        res.status = 1'b0;
        case (op)
            OP_CLEAR: begin
                box_valid  = 1'b0;
                box_top    = '0;
                box_bottom = '0;
                box_left   = '0;
                box_right  = '0;
                pair_id++;
                n_clears++;
            end
            OP_LOAD: begin
                if (r >= dim_in_use(reg_height, MAX_H_DIM) ||
                    c >= dim_in_use(reg_width, MAX_W_DIM)) begin
                    res.status = 1'b1;
                end else begin
                    v = (pa == pb) ? CELL_W'(pa) : WILDCARD;
                    idx = {r, c};
                    meet_store[idx]   = v;
                    cell_written[idx] = 1'b1;
                    cell_pair[idx]    = pair_id;
                    // grow the box around solid cells only; only a clear shrinks it
                    if (v != WILDCARD) begin
                        if (!box_valid) begin
                            box_valid  = 1'b1;
                            box_top    = r;
                            box_bottom = r;
                            box_left   = c;
                            box_right  = c;
                        end else begin
                            if (r < box_top)    box_top    = r;
                            if (r > box_bottom) box_bottom = r;
                            if (c < box_left)   box_left   = c;
                            if (c > box_right)  box_right  = c;
                        end
                        last_solid_row = r;
                        last_solid_col = c;
                    end
                    res.value = v;
                    n_loads++;
                end
            end
            OP_READ: begin
                if (!box_valid || r > box_bottom - box_top || c > box_right - box_left) begin
                    res.status = 1'b1;
                end else begin
                    idx = {ROW_W'(box_top + r), COL_W'(box_left + c)};
                    res.value = meet_store[idx];
                    n_reads++;
                    if (cell_pair[idx] != pair_id) n_stale++;
                end
            end
            default: ;
        endcase
        if (box_valid) begin
            res.top    = box_top;
            res.left   = box_left;
            res.height = DIM_W'(box_bottom - box_top) + DIM_W'(1);
            res.width  = DIM_W'(box_right - box_left) + DIM_W'(1);
        end else begin
            res.top    = '0;
            res.left   = '0;
            res.height = '0;
            res.width  = '0;
        end
        return res;
    endfunction

    // A read is allowed unless it lands inside the box on a cell never written since reset
    function automatic bit read_is_defined(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
        if (!box_valid || r > box_bottom - box_top || c > box_right - box_left) begin
            return 1'b1;
        end
        return cell_written[{ROW_W'(box_top + r), COL_W'(box_left + c)}];
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endfunction

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin : check_results
        meet_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat arrived with no expected result waiting");
                err_count++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                check_field("cell_value", want.value, $signed(m_tdata[8:0]));
                check_field("meet_top", want.top, m_tdata[14:9]);
                check_field("meet_left", want.left, m_tdata[20:15]);
                check_field("meet_height", want.height, m_tdata[27:21]);
                check_field("meet_width", want.width, m_tdata[34:28]);
                check_field("status", want.status, m_tuser);
            end
        end
    end

    // Send one beat after a random gap; predict its result once it is accepted
    task automatic send_pixel_op(opcode_t op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                 logic [PIX_W-1:0] pa, logic [PIX_W-1:0] pb);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, pb, pa, c, r};
        do @(posedge aclk); while (!s_tready);
        pending_results = {pending_results, predict_meet(op, r, c, pa, pb)};
        n_items++;
    endtask

    // Drop valid, drain every expected result, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write
    task automatic write_reg(cfg_index_t idx, logic [DIM_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH:  reg_width  = v;
            REG_IMAGE_HEIGHT: reg_height = v;
            default: ;
        endcase
    endtask

    task automatic set_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // A read with no box, the unused opcode, and a clear straight after reset
    task automatic test_empty_meet();
        send_pixel_op(OP_READ, 6'd0, 6'd0, 8'd0, 8'd0);
        send_pixel_op(OP_NONE, '1, '1, '1, '1);
        send_pixel_op(OP_CLEAR, '1, '1, '1, '1);
    endtask

    // Loads at the four image corners with extreme pixels, under the reset dimensions
    task automatic test_corner_loads();
        send_pixel_op(OP_LOAD, 6'd0, 6'd0, 8'h00, 8'h00);
        send_pixel_op(OP_LOAD, 6'd63, 6'd63, 8'hFF, 8'hFF);
        send_pixel_op(OP_LOAD, 6'd0, 6'd63, 8'h00, 8'hFF);
        send_pixel_op(OP_LOAD, 6'd63, 6'd0, 8'hAA, 8'h55);
        send_pixel_op(OP_READ, 6'd63, 6'd63, 8'd0, 8'd0);
        send_pixel_op(OP_READ, 6'd0, 6'd63, 8'd0, 8'd0);
        send_pixel_op(OP_READ, 6'd0, 6'd0, 8'd0, 8'd0);
    endtask

    // Overwrite a solid cell with a wildcard, then read cells left over from the earlier pair
    task automatic test_overwrite_and_stale();
        send_pixel_op(OP_LOAD, 6'd63, 6'd63, 8'd1, 8'd2);
        send_pixel_op(OP_READ, 6'd63, 6'd63, 8'd0, 8'd0);
        send_pixel_op(OP_CLEAR, 6'd0, 6'd0, 8'd0, 8'd0);
        send_pixel_op(OP_LOAD, 6'd0, 6'd63, 8'd7, 8'd7);
        send_pixel_op(OP_LOAD, 6'd63, 6'd0, 8'd9, 8'd9);
        send_pixel_op(OP_READ, 6'd63, 6'd63, 8'd0, 8'd0);
        send_pixel_op(OP_READ, 6'd0, 6'd0, 8'd0, 8'd0);
    endtask

    // Extreme dimension settings, loads just outside and inside, reads past the box
    task automatic test_image_bounds();
        wait_idle();
        write_reg(REG_UNUSED_2, 7'h7F);
        cfg_valid <= 1'b0;
        set_dims(7'd0, 7'd127);
        send_pixel_op(OP_LOAD, 6'd0, 6'd1, 8'd3, 8'd3);
        send_pixel_op(OP_LOAD, 6'd63, 6'd0, 8'd3, 8'd3);
        set_dims(7'd64, 7'd1);
        send_pixel_op(OP_LOAD, 6'd1, 6'd0, 8'd5, 8'd5);
        send_pixel_op(OP_LOAD, 6'd0, 6'd63, 8'h11, 8'h11);
        set_dims(7'd5, 7'd3);
        send_pixel_op(OP_LOAD, 6'd3, 6'd4, 8'h5A, 8'h5A);
        send_pixel_op(OP_LOAD, 6'd2, 6'd4, 8'h5A, 8'h5A);
        send_pixel_op(OP_CLEAR, 6'd0, 6'd0, 8'd0, 8'd0);
        send_pixel_op(OP_LOAD, 6'd1, 6'd1, 8'd4, 8'd4);
        send_pixel_op(OP_READ, 6'd0, 6'd1, 8'd0, 8'd0);
        send_pixel_op(OP_READ, 6'd1, 6'd0, 8'd0, 8'd0);
        send_pixel_op(OP_READ, 6'd0, 6'd0, 8'd0, 8'd0);
    endtask

    // Random pairs: mostly in-range loads and in-box reads, with clears and noise mixed in
    task automatic test_random_mix(int count, int idle_pct, int stall_pct,
                                   logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        int pick;
        int tries;
        int rows;
        int cols;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic [PIX_W-1:0] pa;
        logic [PIX_W-1:0] pb;
        set_dims(w, h);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        rows = dim_in_use(h, MAX_H_DIM);
        cols = dim_in_use(w, MAX_W_DIM);
        send_pixel_op(OP_CLEAR, ROW_W'($urandom), COL_W'($urandom),
                      PIX_W'($urandom), PIX_W'($urandom));
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            r  = ROW_W'($urandom);
            c  = COL_W'($urandom);
            pa = PIX_W'($urandom);
            pb = PIX_W'($urandom);
            if (pick < 6) begin
                send_pixel_op(OP_CLEAR, r, c, pa, pb);
            end else if (pick < 9) begin
                send_pixel_op(OP_NONE, r, c, pa, pb);
            end else if (pick < 62) begin
                if ($urandom_range(9) != 0) begin
                    r = ROW_W'($urandom_range(rows - 1));
                    c = COL_W'($urandom_range(cols - 1));
                end
                if ($urandom_range(9) < 6) pb = pa;
                send_pixel_op(OP_LOAD, r, c, pa, pb);
            end else begin
                // steer reads away from cells never written; fall back to the last solid cell
                tries = 0;
                do begin
                    if (box_valid && $urandom_range(9) != 0) begin
                        r = ROW_W'($urandom_range(box_bottom - box_top));
                        c = COL_W'($urandom_range(box_right - box_left));
                    end else begin
                        r = ROW_W'($urandom);
                        c = COL_W'($urandom);
                    end
                    tries++;
                end while (!read_is_defined(r, c) && tries < 8);
                if (!read_is_defined(r, c)) begin
                    r = last_solid_row - box_top;
                    c = last_solid_col - box_left;
                end
                send_pixel_op(OP_READ, r, c, pa, pb);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_meet();
        test_corner_loads();
        test_overwrite_and_stale();
        test_image_bounds();
        test_random_mix(130, 0, 0, 7'd64, 7'd64);
        test_random_mix(130, 76, 0, 7'd8, 7'd5);
        test_random_mix(130, 0, 76, 7'd127, 7'd0);
        test_random_mix(130, 20, 20, DIM_W'($urandom_range(1, 64)),
                        DIM_W'($urandom_range(1, 64)));

        // Final drain with a bound
        s_tvalid <= 1'b0;
        for (int k = 0; k < 4000 && pending_results.size() != 0; k++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            err_count++;
        end

        $display("Sent %0d beats over %0d dimension settings: %0d loads, %0d in-box reads,",
                 n_items, n_settings, n_loads, n_reads);
        $display("%0d clears; compared %0d result beats, %0d reads hit cells of an earlier pair.",
                 n_clears, n_checked, n_stale);
        if (err_count == 0) begin
            $display("image_pair_meet_bounding_box: match");
        end else begin
            $display("image_pair_meet_bounding_box: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Run timed out before all results arrived.");
        $display("image_pair_meet_bounding_box: mismatch");
        $finish;
    end

endmodule
